>>> rtl/mkd_pkg.sv
// ----------------------------------------------------------------------------
// Matrix key debouncer package
// Sizes, reset values and beat types shared by the debouncer modules.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // Matrix geometry; key index is row * NumCols + col
  localparam int NumRows = 4;
  localparam int NumCols = 4;
  localparam int NumKeys = NumRows * NumCols;

  // Field widths fixed by the host interface
  localparam int MapW  = 16;
  localparam int TimeW = 32;
  localparam int DebW  = 16;

  // Debounce time after reset, in milliseconds
  localparam logic [DebW-1:0] DebounceReset = DebW'(50);

  // One scan from the host
  typedef struct packed {
    logic [MapW-1:0]  raw_keys;
    logic [TimeW-1:0] now_ms;
    logic [MapW-1:0]  clear_press_events;
    logic [MapW-1:0]  clear_release_events;
  } mkd_in_t;

  // One result per scan
  typedef struct packed {
    logic [MapW-1:0] stable_keys;
    logic [MapW-1:0] press_events;
    logic [MapW-1:0] release_events;
    logic            any_pressed;
  } mkd_out_t;

  // Per-key status after the scan, lane to merge stage
  typedef struct packed {
    logic down;
    logic press;
    logic release_ev;
  } mkd_lane_t;

endpackage

>>> rtl/mkd_lane.sv
// ----------------------------------------------------------------------------
// Matrix key debouncer lane
// Four-phase debounce machine and sticky event flags for one key.
// ----------------------------------------------------------------------------
module mkd_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      raw_i,
  input  logic                      clr_press_i,
  input  logic                      clr_release_i,
  input  logic [mkd_pkg::TimeW-1:0] now_i,
  input  logic [mkd_pkg::DebW-1:0]  deb_i,
  output mkd_pkg::mkd_lane_t        status_o
);
  import mkd_pkg::*;

  typedef enum logic [1:0] {
    PhIdle      = 2'd0,
    PhPressFilt = 2'd1,
    PhHeld      = 2'd2,
    PhRelFilt   = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             down_q, down_d;
  logic             press_q, press_d;
  logic             release_q, release_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW-1:0] elapsed;
  logic             timed_out;

  // Wrapping elapsed time since the filter phase began
  assign elapsed   = now_i - start_q;
  assign timed_out = elapsed >= {{(TimeW-DebW){1'b0}}, deb_i};

  // Next state: clears first, then one step of the phase machine
  always_comb begin
    phase_d   = phase_q;
    down_d    = down_q;
    start_d   = start_q;
    press_d   = press_q & ~clr_press_i;
    release_d = release_q & ~clr_release_i;
    unique case (phase_q)
      PhIdle: begin
        down_d = 1'b0;
        if (raw_i) begin
          start_d = now_i;
          phase_d = PhPressFilt;
        end
      end
      PhPressFilt: begin
        if (!raw_i) phase_d = PhIdle;
        // timeout wins over a bounce back
        if (timed_out) begin
          phase_d = PhHeld;
          down_d  = 1'b1;
          press_d = 1'b1;
        end
      end
      PhHeld: begin
        if (!raw_i) begin
          start_d = now_i;
          phase_d = PhRelFilt;
        end
      end
      PhRelFilt: begin
        if (raw_i) phase_d = PhHeld;
        if (timed_out) begin
          phase_d   = PhIdle;
          down_d    = 1'b0;
          release_d = 1'b1;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  // Status seen by the merge stage for this scan
  assign status_o.down       = down_d;
  assign status_o.press      = press_d;
  assign status_o.release_ev = release_d;

  // Phase machine and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      down_q    <= 1'b0;
      press_q   <= 1'b0;
      release_q <= 1'b0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      down_q    <= down_d;
      press_q   <= press_d;
      release_q <= release_d;
    end
  end

  // Filter start time, only read after it was written
  always_ff @(posedge clk_i) begin
    if (en_i) start_q <= start_d;
  end

  // Debounced level follows the phase: down in held and release-filter
  a_down_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    down_q == (phase_q == PhHeld || phase_q == PhRelFilt))
    else $error("key level disagrees with phase");

endmodule

>>> rtl/mkd_merge.sv
// ----------------------------------------------------------------------------
// Matrix key debouncer merge stage
// Packs lane status into the result beat and buffers two results.
// ----------------------------------------------------------------------------
module mkd_merge (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  mkd_pkg::mkd_lane_t [mkd_pkg::NumKeys-1:0] lanes_i,
  output logic                                   full_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output mkd_pkg::mkd_out_t                      out_beat_o
);
  import mkd_pkg::*;

  mkd_out_t           result;
  mkd_out_t           out_q, skid_q;
  logic               out_v_q, skid_v_q;
  logic               pop;
  logic [NumKeys-1:0] down_all;

  // Output maps carry the first MapW keys
  for (genvar g = 0; g < MapW; g++) begin : g_map
    if (g < NumKeys) begin : g_key
      assign result.stable_keys[g]    = lanes_i[g].down;
      assign result.press_events[g]   = lanes_i[g].press;
      assign result.release_events[g] = lanes_i[g].release_ev;
    end else begin : g_none
      assign result.stable_keys[g]    = 1'b0;
      assign result.press_events[g]   = 1'b0;
      assign result.release_events[g] = 1'b0;
    end
  end

  // Any key pressed, every key counts
  for (genvar k = 0; k < NumKeys; k++) begin : g_down
    assign down_all[k] = lanes_i[k].down;
  end
  assign result.any_pressed = |down_all;

  assign pop = out_v_q & ~out_stall_i;

  // Two-entry result buffer: head register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else if (!push_i) begin
        out_v_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_v_q) skid_v_q <= 1'b1;
      else         out_v_q  <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q)    out_q <= skid_q;
      else if (push_i) out_q <= result;
    end else if (push_i) begin
      if (out_v_q) skid_q <= result;
      else         out_q  <= result;
    end
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_beat_o  = out_q;

  // Skid entry is only used behind a held head entry
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry without head entry");

  // No beat may arrive while both entries are taken
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && skid_v_q))
    else $error("result buffer overflow");

  // A beat pushed into an empty buffer shows up next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !out_v_q) |=> out_v_q)
    else $error("accepted scan lost");

endmodule

>>> rtl/matrix_key_debouncer.sv
// ----------------------------------------------------------------------------
// Matrix key debouncer
// Per-key debounce of a scanned key matrix with sticky press/release events.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | beat
//  ---------+-----------+----------------------+----------------------------
//  cfg      | in        | cfg_we_i             | cfg_wdata_i (debounce ms)
//  scan     | in        | in_valid_i/in_stall_o | in_beat_i  (mkd_in_t)
//  result   | out       | out_valid_o/out_stall_i | out_beat_o (mkd_out_t)
//
//  One scan per cycle while in_stall_o is low; all key lanes step in the
//  same cycle, and the result is registered.
//  A two-entry result buffer lets scans continue while a result waits;
//  in_stall_o rises only when both entries are full.
//  Reset puts every key idle, clears all flags and sets debounce to 50 ms.
// ----------------------------------------------------------------------------
module matrix_key_debouncer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [mkd_pkg::DebW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  mkd_pkg::mkd_in_t         in_beat_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mkd_pkg::mkd_out_t        out_beat_o
);
  import mkd_pkg::*;

  logic [DebW-1:0]            deb_q;
  logic                       accept;
  logic                       full;
  mkd_lane_t [NumKeys-1:0]    lane_st;

  // Debounce time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) deb_q <= DebounceReset;
    else if (cfg_we_i) deb_q <= cfg_wdata_i;
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  // One lane per key; keys past the map width see no raw level or clears
  for (genvar k = 0; k < NumKeys; k++) begin : g_lane
    logic raw, clr_p, clr_r;
    if (k < MapW) begin : g_in
      assign raw   = in_beat_i.raw_keys[k];
      assign clr_p = in_beat_i.clear_press_events[k];
      assign clr_r = in_beat_i.clear_release_events[k];
    end else begin : g_out
      assign raw   = 1'b0;
      assign clr_p = 1'b0;
      assign clr_r = 1'b0;
    end

    mkd_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (accept),
      .raw_i         (raw),
      .clr_press_i   (clr_p),
      .clr_release_i (clr_r),
      .now_i         (in_beat_i.now_ms),
      .deb_i         (deb_q),
      .status_o      (lane_st[k])
    );
  end

  // Merge lanes into the result beat
  mkd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .lanes_i     (lane_st),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
